// ===== design/rsva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsva_pkg;

  // default store dimensions
  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  // field widths
  localparam int CMD_W    = 2;
  localparam int MAG_W    = 16;
  localparam int COORD_W  = 11;
  localparam int DIM_W    = 9;
  localparam int ORIENT_W = 17;
  localparam int MSUM_W   = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // saturation floors of the two sums
  localparam logic [ORIENT_W-1:0] ORIENT_MIN = {1'b1, {(ORIENT_W-1){1'b0}}};
  localparam logic [MSUM_W-1:0]   MSUM_MIN   = {1'b1, {(MSUM_W-1){1'b0}}};

  // input command codes
  localparam logic [CMD_W-1:0] CMD_PROJECT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  // what the back end does with a queued word
  typedef enum logic [1:0] {
    OP_NONE,
    OP_VOTE,
    OP_READ,
    OP_CLEAR
  } op_kind_t;

  // classified word, entry address travels alongside
  typedef struct packed {
    op_kind_t           kind;
    logic               in_range;
    logic [MAG_W-1:0]   magnitude;
  } op_t;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

// ===== design/rsva_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsva_queue import rsva_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output logic                  empty
);

  // two-entry ring
  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign head_data = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/rsva_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsva_front import rsva_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int DEPTH   = MAX_ROWS * MAX_COLS,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        cfg_write,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [CMD_W-1:0]            command,
  input  wire logic [MAG_W-1:0]            magnitude,
  input  wire logic signed [COORD_W-1:0]   target_col,
  input  wire logic signed [COORD_W-1:0]   target_row,
  // toward the queue
  output logic                             push,
  output op_t                              push_op,
  output logic [ADDR_W-1:0]                push_addr,
  input  wire logic                        queue_full,
  input  wire back_status_t                back_status
);

  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] col_count;
  logic [MAG_W-1:0] threshold;

  logic [COORD_W-1:0]   rows_eff;
  logic [COORD_W-1:0]   cols_eff;
  logic                 row_ok;
  logic                 col_ok;
  logic                 inr;
  logic [COORD_W-2:0]   row_idx;
  logic [COORD_W-2:0]   col_idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 9'd256;
      col_count <= 9'd256;
      threshold <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data[DIM_W-1:0];
        REG_COL_COUNT: col_count <= cfg_data[DIM_W-1:0];
        REG_THRESHOLD: threshold <= cfg_data[MAG_W-1:0];
        default:       ;
      endcase
    end
  end

  // effective dimensions, clipped to the store size
  always_comb begin
    rows_eff = (COORD_W'(row_count) > COORD_W'(MAX_ROWS)) ? COORD_W'(MAX_ROWS)
                                                         : COORD_W'(row_count);
    cols_eff = (COORD_W'(col_count) > COORD_W'(MAX_COLS)) ? COORD_W'(MAX_COLS)
                                                         : COORD_W'(col_count);
  end

  // bounds check on 1-based coordinates
  always_comb begin
    row_ok  = !target_row[COORD_W-1] && (target_row != '0) &&
              ({1'b0, target_row[COORD_W-2:0]} <= rows_eff);
    col_ok  = !target_col[COORD_W-1] && (target_col != '0) &&
              ({1'b0, target_col[COORD_W-2:0]} <= cols_eff);
    inr     = row_ok && col_ok;
    row_idx = target_row[COORD_W-2:0] - 1'b1;
    col_idx = target_col[COORD_W-2:0] - 1'b1;
  end

  // column-major entry address
  assign push_addr = ADDR_W'(ADDR_W'(col_idx) * ADDR_W'(MAX_ROWS)) + ADDR_W'(row_idx);

  // classify the word
  always_comb begin
    push_op.magnitude = magnitude;
    push_op.in_range  = inr;
    push_op.kind      = OP_NONE;
    case (command)
      CMD_PROJECT: begin
        if (inr && (magnitude > threshold)) begin
          push_op.kind = OP_VOTE;
        end
      end
      CMD_READ: begin
        if (inr) begin
          push_op.kind = OP_READ;
        end
      end
      CMD_READ_CLEAR: begin
        if (inr) begin
          push_op.kind = OP_CLEAR;
        end
      end
      default: begin
        push_op.in_range = 1'b0;
      end
    endcase
  end

  // accept when the queue has room and the store is ready
  assign in_stall = queue_full || back_status.clearing;
  assign push     = in_valid && !in_stall;

endmodule

`default_nettype wire

// ===== design/rsva_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsva_back import rsva_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int DEPTH   = MAX_ROWS * MAX_COLS,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int ENTRY_W = ORIENT_W + MSUM_W
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // from the queue
  input  wire logic                      queue_empty,
  input  wire op_t                       head_op,
  input  wire logic [ADDR_W-1:0]         head_addr,
  output logic                           pop,
  output back_status_t                   status,
  // output channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           vote_taken,
  output logic                           in_range,
  output logic signed [ORIENT_W-1:0]     orientation_sum,
  output logic signed [MSUM_W-1:0]       magnitude_sum
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t              state;
  op_t                 op;
  logic [ADDR_W-1:0]   op_addr;
  logic [ADDR_W-1:0]   clr_cnt;

  logic [ENTRY_W-1:0]  store [DEPTH];
  logic [ENTRY_W-1:0]  rdata;
  logic [ADDR_W-1:0]   rd_addr;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  logic [ORIENT_W-1:0] o_cur;
  logic [MSUM_W-1:0]   m_cur;
  logic [ORIENT_W-1:0] o_new;
  logic [MSUM_W:0]     m_diff;
  logic [MSUM_W-1:0]   m_new;
  logic                out_free;
  logic                retire;
  logic                is_read;

  assign status.clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && !queue_empty;
  assign out_free = !out_valid || !out_stall;
  assign retire   = (state == ST_EXEC) && out_free;

  // reads return the entry, everything else returns zero sums
  assign is_read  = (op.kind == OP_READ) || (op.kind == OP_CLEAR);

  // read the queue head while idle, the held word otherwise
  assign rd_addr = (state == ST_IDLE) ? head_addr : op_addr;

  // saturating vote update
  always_comb begin
    o_cur  = rdata[ENTRY_W-1:MSUM_W];
    m_cur  = rdata[MSUM_W-1:0];
    o_new  = (o_cur == ORIENT_MIN) ? o_cur : o_cur - 1'b1;
    m_diff = {m_cur[MSUM_W-1], m_cur} - {{(MSUM_W+1-MAG_W){1'b0}}, op.magnitude};
    m_new  = (m_diff[MSUM_W] != m_diff[MSUM_W-1]) ? MSUM_MIN : m_diff[MSUM_W-1:0];
  end

  // store write port: clearing pass or retiring word
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = op_addr;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
    end else if (retire) begin
      case (op.kind)
        OP_VOTE: begin
          wr_en   = 1'b1;
          wr_data = {o_new, m_new};
        end
        OP_CLEAR: begin
          wr_en = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    rdata <= store[rd_addr];
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  // sequencer and output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= retire || (out_valid && out_stall);
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            op      <= head_op;
            op_addr <= head_addr;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            vote_taken      <= (op.kind == OP_VOTE);
            in_range        <= op.in_range;
            orientation_sum <= is_read ? o_cur : '0;
            magnitude_sum   <= is_read ? m_cur : '0;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/radial_symmetry_vote_accumulator.sv =====
// Radial symmetry vote accumulator.
// Input channel (in_valid / in_stall) takes one word per handshake: a command,
// a 12.4 gradient magnitude and a 1-based target column and row. A project
// word above threshold and in range decrements the entry's orientation count
// and subtracts the magnitude from its magnitude sum, both saturating. Read
// words return an entry; read-and-clear also zeroes it.
// Output channel (out_valid / out_stall) returns exactly one word per input.
// Configuration: cfg_write with cfg_index 0 row_count, 1 col_count, 2 threshold.
// The store sequencer handles one word at a time, as a read-modify-write of the
// entry store (registered read while idle, then update and write as it retires);
// it takes the next word from the queue only after the last one has retired.
// A 2-word queue sits between the classifier and the store sequencer; a
// stalled output word holds while up to three more words are taken in behind it.
// Reset: after rst, a clearing pass writes zero to every entry, one per cycle,
// MAX_ROWS*MAX_COLS entries in all (65536 by default); in_stall is high meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module radial_symmetry_vote_accumulator import rsva_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [CMD_W-1:0]          command,
  input  wire logic [MAG_W-1:0]          magnitude,
  input  wire logic signed [COORD_W-1:0] target_col,
  input  wire logic signed [COORD_W-1:0] target_row,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           vote_taken,
  output logic                           in_range,
  output logic signed [ORIENT_W-1:0]     orientation_sum,
  output logic signed [MSUM_W-1:0]       magnitude_sum
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW_W   = $bits(op_t) + ADDR_W;

  logic              push;
  op_t               push_op;
  logic [ADDR_W-1:0] push_addr;
  logic              queue_full;
  logic              queue_empty;
  logic              pop;
  logic [QW_W-1:0]   head_word;
  op_t               head_op;
  logic [ADDR_W-1:0] head_addr;
  back_status_t      back_status;

  assign head_op   = head_word[QW_W-1:ADDR_W];
  assign head_addr = head_word[ADDR_W-1:0];

  // classifier and configuration
  rsva_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .magnitude   (magnitude),
    .target_col  (target_col),
    .target_row  (target_row),
    .push        (push),
    .push_op     (push_op),
    .push_addr   (push_addr),
    .queue_full  (queue_full),
    .back_status (back_status)
  );

  // decoupling queue
  rsva_queue #(
    .WIDTH (QW_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_op, push_addr}),
    .full      (queue_full),
    .pop       (pop),
    .head_data (head_word),
    .empty     (queue_empty)
  );

  // store sequencer
  rsva_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_empty     (queue_empty),
    .head_op         (head_op),
    .head_addr       (head_addr),
    .pop             (pop),
    .status          (back_status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .vote_taken      (vote_taken),
    .in_range        (in_range),
    .orientation_sum (orientation_sum),
    .magnitude_sum   (magnitude_sum)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rsva_pkg::*;

  localparam int ROWS_MAX = DEF_MAX_ROWS;
  localparam int COLS_MAX = DEF_MAX_COLS;
  localparam int STORE_DEPTH = ROWS_MAX * COLS_MAX;
  localparam int ORIENT_FLOOR = -65536;
  localparam longint MSUM_FLOOR = -(64'sd1 <<< 32);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 250000;
  localparam int HOT_VOTES = 64;
  localparam int HOT_ENTRIES = 6;

  typedef struct packed {
    logic                       vote;
    logic                       inr;
    logic signed [ORIENT_W-1:0] orient;
    logic signed [MSUM_W-1:0]   msum;
  } entry_result_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [CMD_W-1:0]          command;
  logic [MAG_W-1:0]          magnitude;
  logic signed [COORD_W-1:0] target_col;
  logic signed [COORD_W-1:0] target_row;
  logic                      out_valid;
  logic                      out_stall;
  logic                      vote_taken;
  logic                      in_range;
  logic signed [ORIENT_W-1:0] orientation_sum;
  logic signed [MSUM_W-1:0]   magnitude_sum;

  // predictor state: registers and both entry stores
  logic [DIM_W-1:0] row_count_q = 9'd256;
  logic [DIM_W-1:0] col_count_q = 9'd256;
  logic [MAG_W-1:0] threshold_q = '0;
  int               orient_store [STORE_DEPTH];
  longint           msum_store [STORE_DEPTH];
  entry_result_t    pending_results [$];

  bit idling_on = 1'b0;
  int hold_requests = 0;
  int error_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int votes_predicted = 0;
  int nonzero_reads = 0;
  int quiet_cycles = 0;

  radial_symmetry_vote_accumulator i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .magnitude       (magnitude),
    .target_col      (target_col),
    .target_row      (target_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .vote_taken      (vote_taken),
    .in_range        (in_range),
    .orientation_sum (orientation_sum),
    .magnitude_sum   (magnitude_sum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // counts above the store size act as the store size
  function automatic int eff_dim(logic [DIM_W-1:0] v, int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // apply one word to the predicted stores and work out its result
  function automatic entry_result_t accumulate_vote(logic [CMD_W-1:0] cmd,
                                                    logic [MAG_W-1:0] mag,
                                                    logic signed [COORD_W-1:0] col,
                                                    logic signed [COORD_W-1:0] row);
    entry_result_t r;
    int rows_eff, cols_eff, c, rw, addr, oc;
    longint mc;
    bit hit;
    rows_eff = eff_dim(row_count_q, ROWS_MAX);
    cols_eff = eff_dim(col_count_q, COLS_MAX);
    c = int'(col);
    rw = int'(row);
    hit = (rw >= 1) && (rw <= rows_eff) && (c >= 1) && (c <= cols_eff);
    addr = hit ? (c - 1) * ROWS_MAX + (rw - 1) : 0;
    r = '0;
    r.inr = hit;
    case (cmd)
      CMD_PROJECT: begin
        if (hit && mag > threshold_q) begin
          oc = orient_store[addr];
          if (oc > ORIENT_FLOOR) oc = oc - 1;
          mc = msum_store[addr] - longint'(mag);
          if (mc < MSUM_FLOOR) mc = MSUM_FLOOR;
          orient_store[addr] = oc;
          msum_store[addr] = mc;
          r.vote = 1'b1;
          votes_predicted++;
        end
      end
      CMD_READ, CMD_READ_CLEAR: begin
        if (hit) begin
          r.orient = ORIENT_W'(orient_store[addr]);
          r.msum = MSUM_W'(msum_store[addr]);
          if (orient_store[addr] != 0) nonzero_reads++;
          if (cmd == CMD_READ_CLEAR) begin
            orient_store[addr] = 0;
            msum_store[addr] = 0;
          end
        end
      end
      default: begin
        r.inr = 1'b0;
      end
    endcase
    return r;
  endfunction

  // offer one word, wait for it to be taken, then predict it
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [MAG_W-1:0] mag,
                           logic signed [COORD_W-1:0] col,
                           logic signed [COORD_W-1:0] row);
    int gap;
    gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    magnitude <= mag;
    target_col <= col;
    target_row <= row;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(accumulate_vote(cmd, mag, col, row));
    words_sent++;
  endtask

  // drop valid and wait until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_ROW_COUNT: row_count_q = data[DIM_W-1:0];
      REG_COL_COUNT: col_count_q = data[DIM_W-1:0];
      REG_THRESHOLD: threshold_q = data[MAG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_image(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
                           logic [CFG_DATA_W-1:0] thr);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_THRESHOLD, thr);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // coordinates on and just past the image border, plus the field extremes and random values up to 256
  function automatic logic signed [COORD_W-1:0] boundary_coord(int dim);
    case ($urandom_range(0, 6))
      0: return COORD_W'(0);
      1: return COORD_W'(1);
      2: return COORD_W'(dim);
      3: return COORD_W'(dim + 1);
      4: return COORD_W'(-1024);
      5: return COORD_W'(1023);
      default: return COORD_W'($urandom_range(1, 256));
    endcase
  endfunction

  // mostly votes and reads on a few hot entries, some border and noise words
  task automatic send_mixed(int n);
    int rows_eff, cols_eff, pick, k;
    logic signed [COORD_W-1:0] hot_col [HOT_ENTRIES];
    logic signed [COORD_W-1:0] hot_row [HOT_ENTRIES];
    logic [MAG_W-1:0] mag;
    logic [CMD_W-1:0] cmd;
    logic signed [COORD_W-1:0] col, row;
    rows_eff = eff_dim(row_count_q, ROWS_MAX);
    cols_eff = eff_dim(col_count_q, COLS_MAX);
    for (k = 0; k < HOT_ENTRIES; k++) begin
      hot_col[k] = COORD_W'($urandom_range(1, (cols_eff > 0) ? cols_eff : 1));
      hot_row[k] = COORD_W'($urandom_range(1, (rows_eff > 0) ? rows_eff : 1));
    end
    repeat (n) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, HOT_ENTRIES - 1);
      col = hot_col[k];
      row = hot_row[k];
      mag = MAG_W'($urandom);
      if ($urandom_range(0, 3) == 0) mag = MAG_W'(threshold_q + $urandom_range(0, 1));
      if (pick < 55) begin
        cmd = CMD_PROJECT;
      end else if (pick < 75) begin
        cmd = $urandom_range(0, 1) ? CMD_READ : CMD_READ_CLEAR;
      end else if (pick < 90) begin
        cmd = CMD_W'($urandom_range(0, 3));
        col = boundary_coord(cols_eff);
        row = boundary_coord(rows_eff);
      end else begin
        cmd = CMD_W'($urandom_range(0, 3));
        col = COORD_W'($urandom);
        row = COORD_W'($urandom);
      end
      send_word(cmd, mag, col, row);
    end
  endtask

  // border, threshold and command cases at the reset image size
  task automatic test_directed();
    idling_on = 1'b1;
    send_word(CMD_READ, 16'h0000, 11'sd1, 11'sd1);
    send_word(CMD_PROJECT, 16'h0000, 11'sd1, 11'sd1);
    send_word(CMD_PROJECT, 16'h0001, 11'sd1, 11'sd1);
    send_word(CMD_PROJECT, 16'hFFFF, 11'sd1, 11'sd1);
    send_word(CMD_READ, 16'h0000, 11'sd1, 11'sd1);
    send_word(CMD_READ_CLEAR, 16'hFFFF, 11'sd1, 11'sd1);
    send_word(CMD_READ, 16'h0000, 11'sd1, 11'sd1);
    send_word(CMD_PROJECT, 16'hFFFF, 11'sd256, 11'sd256);
    send_word(CMD_READ, 16'h0000, 11'sd256, 11'sd256);
    send_word(CMD_PROJECT, 16'hFFFF, 11'sd0, 11'sd1);
    send_word(CMD_PROJECT, 16'hFFFF, 11'sd1, 11'sd0);
    send_word(CMD_PROJECT, 16'hFFFF, 11'sd257, 11'sd256);
    send_word(CMD_PROJECT, 16'hFFFF, 11'sd256, 11'sd257);
    send_word(CMD_PROJECT, 16'hFFFF, -11'sd1024, 11'sd1023);
    send_word(CMD_PROJECT, 16'hFFFF, 11'sd1023, -11'sd1);
    send_word(CMD_READ_CLEAR, 16'h0000, 11'sd0, 11'sd5);
    send_word(CMD_UNUSED, 16'hFFFF, 11'sd256, 11'sd256);
    send_word(CMD_READ, 16'h0000, 11'sd256, 11'sd256);
    send_word(CMD_READ_CLEAR, 16'h0000, 11'sd256, 11'sd256);
    send_word(CMD_READ, 16'h0000, 11'sd256, 11'sd256);
    send_word(CMD_PROJECT, 16'h8000, 11'sd1, 11'sd256);
    send_word(CMD_READ, 16'h0000, 11'sd1, 11'sd256);
  endtask

  // back-to-back full-scale votes on one entry, read now and then
  task automatic test_hot_entry();
    int n;
    drain_results();
    set_image(16'd256, 16'd256, 16'd0);
    idling_on = 1'b0;
    for (n = 1; n <= HOT_VOTES; n++) begin
      send_word(CMD_PROJECT, 16'hFFFF, 11'sd3, 11'sd7);
      if (n % 16 == 0)
        send_word(CMD_READ, 16'h0000, 11'sd3, 11'sd7);
    end
  endtask

  // image size and threshold extremes, including zero and oversized counts
  task automatic test_config_sweep();
    int p;
    for (p = 0; p < 6; p++) begin
      drain_results();
      case (p)
        0: set_image(16'd1, 16'd1, 16'hFFFF);
        1: set_image(16'd1, 16'd1, 16'd0);
        2: set_image(16'hFE00, 16'd5, 16'd0);
        3: set_image(16'hFFFF, 16'd300, 16'd100);
        4: set_image(16'd256, 16'd1, 16'h8000);
        default: begin
          write_reg(REG_UNUSED, 16'hFFFF);
          set_image(16'd256, 16'd256, 16'd1);
        end
      endcase
      idling_on = (p % 2 == 0);
      send_mixed(40);
    end
  endtask

  // receiver holds off while words keep coming, so the input backs up
  task automatic test_backpressure();
    drain_results();
    set_image(16'd16, 16'd16, 16'd0);
    idling_on = 1'b0;
    hold_requests++;
    send_mixed(30);
  endtask

  // random image settings, mostly well-formed traffic; last segment runs flat out
  task automatic test_random_mix();
    int seg;
    logic [CFG_DATA_W-1:0] rows, cols, thr;
    for (seg = 0; seg < 6; seg++) begin
      drain_results();
      rows = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                              : $urandom_range(1, 256));
      cols = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                              : $urandom_range(1, 256));
      thr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      set_image(rows, cols, thr);
      idling_on = (seg < 5) && ($urandom_range(0, 3) != 0);
      send_mixed(150);
    end
  endtask

  // receiver stall: random bursts, plus the long hold when one is requested
  initial begin
    int burst_left, hold_left, holds_done;
    burst_left = 0;
    hold_left = 0;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare each returned word with the oldest prediction
  always @(posedge clk) begin : check_results
    entry_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no word outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (vote_taken !== want.vote) begin
          $error("vote_taken: expected %0d, got %0d", want.vote, vote_taken);
          error_count++;
        end
        if (in_range !== want.inr) begin
          $error("in_range: expected %0d, got %0d", want.inr, in_range);
          error_count++;
        end
        if (orientation_sum !== want.orient) begin
          $error("orientation_sum: expected %0d, got %0d", want.orient, orientation_sum);
          error_count++;
        end
        if (magnitude_sum !== want.msum) begin
          $error("magnitude_sum: expected %0d, got %0d", want.msum, magnitude_sum);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_ROW_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_PROJECT;
    magnitude = '0;
    target_col = '0;
    target_row = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_hot_entry();
    test_config_sweep();
    test_backpressure();
    test_random_mix();

    drain_results();
    repeat (20) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d votes, %0d reads of nonzero entries",
             words_sent, results_checked, votes_predicted, nonzero_reads);
    $display("covered border and threshold edges, zero and oversized image sizes,");
    $display("repeated votes on one entry, unused codes and a long output hold");
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
